[design/eaq_pkg.sv]
// Shared types and constants for the Euler angle to quaternion converter.
`default_nettype none
package eaq_pkg;
   localparam int ANGLE_W        = 16;
   localparam int QUAT_W         = 16;
   localparam int TRIG_W         = 32;
   localparam int ZW             = 34;
   localparam int PROD_W         = 64;
   localparam int RND_W          = 18;
   localparam int TAB_LEN        = 24;
   localparam int STAGES_DEFAULT = 14;
   localparam int LANES          = 3;

   typedef logic signed [ZW-1:0]     angle_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      trig_type c;
      trig_type s;
   } sincos_type;

   localparam angle_type ANG_PI      = 34'sd3373259426;
   localparam angle_type ANG_HALF_PI = 34'sd1686629713;
   localparam trig_type  CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [RND_W-1:0] Q_ONE = 18'sd16384;

   localparam angle_type ATAN_TAB [TAB_LEN] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
      34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
      34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
      34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
      34'sd1023,      34'sd511,       34'sd255,       34'sd127
   };
endpackage
`default_nettype wire

[design/eaq_cordic_cell.sv]
// One CORDIC rotation cell: a registered micro-rotation handed to the next cell.
`default_nettype none
module eaq_cordic_cell
   import eaq_pkg::*;
#(
   parameter int STAGE_INDEX = 0
) (
   input  logic      clock,
   input  trig_type  prev_x,
   input  trig_type  prev_y,
   input  angle_type prev_z,
   output trig_type  x,
   output trig_type  y,
   output angle_type z
);
   trig_type  x_ff, y_ff, x_in, y_in, dx, dy;
   angle_type z_ff, z_in;

   always_comb begin
      dx = prev_y >>> STAGE_INDEX;
      dy = prev_x >>> STAGE_INDEX;
      if (prev_z >= 0) begin
         x_in = prev_x - dx;
         y_in = prev_y + dy;
         z_in = prev_z - ATAN_TAB[STAGE_INDEX];
      end else begin
         x_in = prev_x + dx;
         y_in = prev_y - dy;
         z_in = prev_z + ATAN_TAB[STAGE_INDEX];
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;
endmodule
`default_nettype wire

[design/eaq_combine.sv]
// Quaternion products: pair products, triple products, then round and clamp.
`default_nettype none
module eaq_combine
   import eaq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  sincos_type        pitch,
   input  sincos_type        yaw,
   input  sincos_type        roll,
   output logic              out_valid,
   output logic [QUAT_W-1:0] quat_x,
   output logic [QUAT_W-1:0] quat_y,
   output logic [QUAT_W-1:0] quat_z,
   output logic [QUAT_W-1:0] quat_w
);
   logic [2:0] valid_ff, valid_in;
   trig_type crsp_ff, crcp_ff, srsp_ff, srcp_ff;
   trig_type crsp_in, crcp_in, srsp_in, srcp_in;
   trig_type cy_ff, sy_ff;
   prod_type m_crsp, m_crcp, m_srsp, m_srcp;
   prod_type p_ff [8];
   prod_type p_in [8];
   prod_type sum [4];
   logic [QUAT_W-1:0] q_ff [4];
   logic [QUAT_W-1:0] q_in [4];

   function automatic trig_type round30(input prod_type v);
      prod_type t;
      t = (v + (prod_type'(1) <<< 29)) >>> 30;
      return t[TRIG_W-1:0];
   endfunction

   function automatic logic [QUAT_W-1:0] finish(input prod_type v);
      prod_type t;
      logic signed [RND_W-1:0] r;
      t = (v + (prod_type'(1) <<< 45)) >>> 46;
      r = t[RND_W-1:0];
      if (r > Q_ONE) r = Q_ONE;
      if (r < -Q_ONE) r = -Q_ONE;
      return r[QUAT_W-1:0];
   endfunction

   always_comb begin
      m_crsp  = prod_type'(roll.c) * prod_type'(pitch.s);
      m_crcp  = prod_type'(roll.c) * prod_type'(pitch.c);
      m_srsp  = prod_type'(roll.s) * prod_type'(pitch.s);
      m_srcp  = prod_type'(roll.s) * prod_type'(pitch.c);
      crsp_in = round30(m_crsp);
      crcp_in = round30(m_crcp);
      srsp_in = round30(m_srsp);
      srcp_in = round30(m_srcp);
      p_in[0] = prod_type'(crsp_ff) * prod_type'(cy_ff);
      p_in[1] = prod_type'(srcp_ff) * prod_type'(sy_ff);
      p_in[2] = prod_type'(crcp_ff) * prod_type'(sy_ff);
      p_in[3] = prod_type'(srsp_ff) * prod_type'(cy_ff);
      p_in[4] = prod_type'(srcp_ff) * prod_type'(cy_ff);
      p_in[5] = prod_type'(crsp_ff) * prod_type'(sy_ff);
      p_in[6] = prod_type'(crcp_ff) * prod_type'(cy_ff);
      p_in[7] = prod_type'(srsp_ff) * prod_type'(sy_ff);
      sum[0]  = p_ff[0] - p_ff[1];
      sum[1]  = p_ff[2] + p_ff[3];
      sum[2]  = p_ff[4] - p_ff[5];
      sum[3]  = p_ff[6] + p_ff[7];
      for (int k = 0; k < 4; k++) begin
         q_in[k] = finish(sum[k]);
      end
      valid_in = {valid_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crsp_ff <= crsp_in;
      crcp_ff <= crcp_in;
      srsp_ff <= srsp_in;
      srcp_ff <= srcp_in;
      cy_ff   <= yaw.c;
      sy_ff   <= yaw.s;
      p_ff    <= p_in;
      q_ff    <= q_in;
   end

   assign out_valid = valid_ff[2];
   assign quat_x    = q_ff[0];
   assign quat_y    = q_ff[1];
   assign quat_z    = q_ff[2];
   assign quat_w    = q_ff[3];
endmodule
`default_nettype wire

[design/euler_angles_to_quaternion_unit.sv]
// Top level: pitch, yaw, roll in Q3.12 to a unit quaternion in Q1.14.
// Fully pipelined: one triple is taken every clock and busy stays low. Each result
// passes through the fold register, the chain of CORDIC cells (one per stage), the
// sign fix-up register and three product stages. The result is shown on rsp_valid
// for one cycle; the receiver must take it then.
`default_nettype none
module euler_angles_to_quaternion_unit
   import eaq_pkg::*;
#(
   parameter int CORDIC_STAGES = STAGES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ANGLE_W-1:0] req_pitch_angle,
   input  logic [ANGLE_W-1:0] req_yaw_angle,
   input  logic [ANGLE_W-1:0] req_roll_angle,
   output logic               rsp_valid,
   output logic [QUAT_W-1:0]  rsp_quat_x,
   output logic [QUAT_W-1:0]  rsp_quat_y,
   output logic [QUAT_W-1:0]  rsp_quat_z,
   output logic [QUAT_W-1:0]  rsp_quat_w
);
   localparam int LAT = CORDIC_STAGES + 5;

   logic [CORDIC_STAGES+1:0] valid_ff, valid_in;
   logic [ANGLE_W-1:0] raw [LANES];
   trig_type  cx [LANES][CORDIC_STAGES+1];
   trig_type  cy [LANES][CORDIC_STAGES+1];
   angle_type cz [LANES][CORDIC_STAGES+1];
   logic      flip_ff [LANES][CORDIC_STAGES+1];
   sincos_type sc_ff [LANES];
   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign raw[0] = req_pitch_angle;
   assign raw[1] = req_yaw_angle;
   assign raw[2] = req_roll_angle;

   assign valid_in = {valid_ff[CORDIC_STAGES:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      angle_type half_z, z0_in, z0_ff;
      logic      flip0_in;

      always_comb begin
         half_z   = angle_type'($signed(raw[l])) <<< 17;
         z0_in    = half_z;
         flip0_in = 1'b0;
         if (half_z > ANG_HALF_PI) begin
            z0_in    = half_z - ANG_PI;
            flip0_in = 1'b1;
         end else if (half_z < -ANG_HALF_PI) begin
            z0_in    = half_z + ANG_PI;
            flip0_in = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         z0_ff            <= z0_in;
         flip_ff[l][0]    <= flip0_in;
      end

      assign cx[l][0] = CORDIC_GAIN;
      assign cy[l][0] = '0;
      assign cz[l][0] = z0_ff;

      for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
         eaq_cordic_cell #(.STAGE_INDEX(k)) u_cell (
            .clock  (clock),
            .prev_x (cx[l][k]),
            .prev_y (cy[l][k]),
            .prev_z (cz[l][k]),
            .x      (cx[l][k+1]),
            .y      (cy[l][k+1]),
            .z      (cz[l][k+1])
         );
         always_ff @(posedge clock) begin
            flip_ff[l][k+1] <= flip_ff[l][k];
         end
      end

      always_ff @(posedge clock) begin
         if (flip_ff[l][CORDIC_STAGES]) begin
            sc_ff[l].c <= -cx[l][CORDIC_STAGES];
            sc_ff[l].s <= -cy[l][CORDIC_STAGES];
         end else begin
            sc_ff[l].c <= cx[l][CORDIC_STAGES];
            sc_ff[l].s <= cy[l][CORDIC_STAGES];
         end
      end

      logic unused_ok;
      assign unused_ok = ^cz[l][CORDIC_STAGES];
   end

   eaq_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[CORDIC_STAGES+1]),
      .pitch     (sc_ff[0]),
      .yaw       (sc_ff[1]),
      .roll      (sc_ff[2]),
      .out_valid (rsp_valid),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z),
      .quat_w    (rsp_quat_w)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, LAT))
      else $error("result without matching start beat");

   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

   a_range_w: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_quat_w) <= 16384 && $signed(rsp_quat_w) >= -16384))
      else $error("quat_w out of range");
endmodule
`default_nettype wire
